### rtl/core/llte_pkg.sv
// Package for the link latency test engine: test modes, header constants and
// the result record carried through the output stage. No dependencies.
`timescale 1ns / 1ps

package llte_pkg;

	localparam int unsigned COUNT_W = 32;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(5);
	localparam logic [BYTE_W-1:0]  ACK_BYTE     = BYTE_W'(8'h01);

	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_RX     = 2'd1,
		MODE_TX     = 2'd2,
		MODE_ECHO   = 2'd3
	} mode_t;

	// Slot indication on the request side
	localparam logic CMD_RX_BYTE = 1'b0;
	localparam logic CMD_TX_SLOT = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_error;
		logic              test_done;
	} result_t;

endpackage

### rtl/core/link_latency_test_engine_top.sv
// Link latency test engine top level: header decode, test sequencing and a
// two-entry output stage. Depends on llte_pkg.
//
// Channel    | Direction | tdata         | tuser       | tlast
// s_axis     | in        | [7:0] in_byte | [0] cmd     | -
// m_axis     | out       | [7:0] out_byte| [0] is_error| test_done
//
// One request is taken per cycle while s_axis_tready is high; its result,
// if any, goes to the output register or, if it stalls, the skid register.
// Reset clears the mode to header, the count to five and the pattern counter.
// A stalled output holds its result; one further result parks in a skid
// register, and s_axis_tready drops only while that skid register is full.
`timescale 1ns / 1ps

module link_latency_test_engine_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [llte_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0]                      s_axis_tuser,   // [0] cmd
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [llte_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]                      m_axis_tuser,   // [0] is_error
	output logic                            m_axis_tlast    // test_done
);
	import llte_pkg::*;

	mode_t                mode_q, mode_d;
	logic [COUNT_W-1:0]   rem_q, rem_d;
	logic [BYTE_W-1:0]    type_q, type_d;
	logic [COUNT_W-1:0]   len_q, len_d;
	logic [BYTE_W-1:0]    pat_q, pat_d;

	logic                 in_fire;
	logic                 slot;
	logic [BYTE_W-1:0]    in_b;
	logic                 res_valid;
	result_t              res;

	logic                 out_valid_q;
	result_t              out_q;
	logic                 skid_valid_q;
	result_t              skid_q;
	logic                 out_free;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign slot    = s_axis_tuser[0];
	assign in_b    = s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			rem_q  <= HEADER_BYTES;
			type_q <= '0;
			len_q  <= '0;
			pat_q  <= '0;
		end else begin
			mode_q <= mode_d;
			rem_q  <= rem_d;
			type_q <= type_d;
			len_q  <= len_d;
			pat_q  <= pat_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		rem_d     = rem_q;
		type_d    = type_q;
		len_d     = len_q;
		pat_d     = pat_q;
		res_valid = 1'b0;
		res       = '0;
		if (in_fire) begin
			unique case (mode_q)
				MODE_HEADER: begin
					if (slot == CMD_RX_BYTE) begin
						if (rem_q >= HEADER_BYTES || rem_q == '0) begin
							type_d = in_b;
						end else begin
							// length arrives low byte first
							len_d = {in_b, len_q[COUNT_W-1:BYTE_W]};
						end
						if (rem_q > COUNT_W'(1) && rem_q <= HEADER_BYTES) begin
							rem_d = rem_q - COUNT_W'(1);
						end else if (type_d < BYTE_W'(MODE_RX) ||
								type_d > BYTE_W'(MODE_ECHO)) begin
							mode_d       = MODE_HEADER;
							rem_d        = HEADER_BYTES;
							res_valid    = 1'b1;
							res.is_error = 1'b1;
						end else if (len_d == '0) begin
							mode_d = MODE_HEADER;
							rem_d  = HEADER_BYTES;
							if (type_d == BYTE_W'(MODE_RX)) begin
								res_valid     = 1'b1;
								res.out_byte  = ACK_BYTE;
								res.test_done = 1'b1;
							end
						end else begin
							mode_d = mode_t'(type_d[1:0]);
							rem_d  = len_d;
						end
					end
				end
				MODE_RX: begin
					if (slot == CMD_RX_BYTE) begin
						rem_d = rem_q - COUNT_W'(1);
						if (rem_q == COUNT_W'(1)) begin
							mode_d        = MODE_HEADER;
							rem_d         = HEADER_BYTES;
							res_valid     = 1'b1;
							res.out_byte  = ACK_BYTE;
							res.test_done = 1'b1;
						end
					end
				end
				MODE_TX: begin
					res_valid = 1'b1;
					if (slot == CMD_RX_BYTE) begin
						// abandon the test, keep the pattern counter
						mode_d       = MODE_HEADER;
						rem_d        = HEADER_BYTES;
						res.is_error = 1'b1;
					end else begin
						res.out_byte = pat_q;
						pat_d        = pat_q + BYTE_W'(1);
						rem_d        = rem_q - COUNT_W'(1);
						if (rem_q == COUNT_W'(1)) begin
							mode_d        = MODE_HEADER;
							rem_d         = HEADER_BYTES;
							res.test_done = 1'b1;
						end
					end
				end
				MODE_ECHO: begin
					if (slot == CMD_RX_BYTE) begin
						res_valid    = 1'b1;
						res.out_byte = in_b;
						rem_d        = rem_q - COUNT_W'(1);
						if (rem_q == COUNT_W'(1)) begin
							mode_d        = MODE_HEADER;
							rem_d         = HEADER_BYTES;
							res.test_done = 1'b1;
						end
					end
				end
				default: begin
					mode_d = MODE_HEADER;
				end
			endcase
		end
	end

	// Output register with a skid entry behind it
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (out_free) begin
			out_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign s_axis_tready   = !skid_valid_q;
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.out_byte;
	assign m_axis_tuser[0] = out_q.is_error;
	assign m_axis_tlast    = out_q.test_done;

endmodule

### rtl/core/llte_checker.sv
// Port-level checker for the link latency test engine, bound to the top level.
// Depends on llte_pkg for the byte width.
`timescale 1ns / 1ps

module llte_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [llte_pkg::BYTE_W-1:0] s_axis_tdata,
	input  logic [0:0]                  s_axis_tuser,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [llte_pkg::BYTE_W-1:0] m_axis_tdata,
	input  logic [0:0]                  m_axis_tuser,
	input  logic                        m_axis_tlast
);
	import llte_pkg::*;

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// Error results carry a zero byte and never finish a test
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tlast)
		else $error("error result with payload or done flag");

	// Output only fills from an idle state after a request was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("result without request");

	// Ready drops only when a result was held back by the sink
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("ready dropped without output stall");

	logic unused_in;
	assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind link_latency_test_engine_top llte_checker u_llte_checker (.*);
